[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define GAPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define GAPF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gapf_pkg.sv]
`default_nettype none

package gapf_pkg;

  // Result status codes.
  typedef logic [1:0] status_t;

  localparam status_t ST_MAP_DONE   = 2'd0;
  localparam status_t ST_QUERY_DONE = 2'd1;
  localparam status_t ST_STEP_OK    = 2'd2;
  localparam status_t ST_STEP_BAD   = 2'd3;

endpackage

`default_nettype wire

[design/gapf_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module gapf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered and valid in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/grid_astar_path_finder.sv]
// Channel  Handshake              Payload
// in       in_valid / in_stall    req_type, cell_x, cell_y, passable, start_x, start_y,
//                                 target_x, target_y, step_index
// out      out_valid / out_stall  status, path_length, step_x, step_y
// cfg      cfg_write              cfg_index, cfg_data (grid_width, grid_height)
//
// A map write or a step read passes through S_RESULT to the output register; one item is worked on at a time.
// A query first clears the seen marks, one map entry at a time (4096 entries at the
// default size); each heap push then sifts up one level per read and compare, and
// each pop reads the top and the last entry and then sifts down one level at a time.
// After reset the map is cleared in one pass over all 4096 entries; in_stall is high meanwhile.
// A finished result waits in the output register while out_stall is high.
`default_nettype none

module grid_astar_path_finder
  import gapf_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int HEAP_DEPTH = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [5:0]  cell_x,
  input  wire logic [5:0]  cell_y,
  input  wire logic        passable,
  input  wire logic [5:0]  start_x,
  input  wire logic [5:0]  start_y,
  input  wire logic [5:0]  target_x,
  input  wire logic [5:0]  target_y,
  input  wire logic [11:0] step_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output status_t          status,
  output logic [12:0]      path_length,
  output logic [5:0]       step_x,
  output logic [5:0]       step_y,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int AW        = XW + YW;
  localparam int MAP_DEPTH = 1 << AW;
  localparam int NUM_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int LW        = $clog2(NUM_CELLS + 1);
  localparam int PAW       = $clog2(NUM_CELLS);
  localparam int GW        = LW;
  localparam int FW        = LW + 1;
  localparam int KW        = FW + AW;
  localparam int HAW       = $clog2(HEAP_DEPTH);
  localparam int HCW       = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [2:0] DIR_E    = 3'd0;
  localparam logic [2:0] DIR_W    = 3'd1;
  localparam logic [2:0] DIR_S    = 3'd2;
  localparam logic [2:0] DIR_N    = 3'd3;
  localparam logic [2:0] DIR_DONE = 3'd4;

  localparam logic [4:0] S_CLRMAP   = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_RESULT   = 5'd2;
  localparam logic [4:0] S_QCHK     = 5'd3;
  localparam logic [4:0] S_CLRSEEN  = 5'd4;
  localparam logic [4:0] S_INIT     = 5'd5;
  localparam logic [4:0] S_PUSH     = 5'd6;
  localparam logic [4:0] S_UP_RD    = 5'd7;
  localparam logic [4:0] S_UP_CMP   = 5'd8;
  localparam logic [4:0] S_POP      = 5'd9;
  localparam logic [4:0] S_POP_TOP  = 5'd10;
  localparam logic [4:0] S_POP_LAST = 5'd11;
  localparam logic [4:0] S_DN_RD    = 5'd12;
  localparam logic [4:0] S_DN_C1    = 5'd13;
  localparam logic [4:0] S_DN_C2    = 5'd14;
  localparam logic [4:0] S_DN_CMP   = 5'd15;
  localparam logic [4:0] S_EXP      = 5'd16;
  localparam logic [4:0] S_EXP_G    = 5'd17;
  localparam logic [4:0] S_NB       = 5'd18;
  localparam logic [4:0] S_NB_CHK   = 5'd19;
  localparam logic [4:0] S_W1       = 5'd20;
  localparam logic [4:0] S_W1D      = 5'd21;
  localparam logic [4:0] S_W2       = 5'd22;
  localparam logic [4:0] S_W2D      = 5'd23;

  // Manhattan distance between two cells.
  function automatic logic [FW-1:0] hdist(input logic [XW-1:0] ax, input logic [YW-1:0] ay,
                                          input logic [XW-1:0] bx, input logic [YW-1:0] by);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return FW'(dx) + FW'(dy);
  endfunction

  // Control registers.
  logic [4:0]     state, state_next;
  logic [AW-1:0]  clr, clr_next;
  logic [6:0]     grid_width, grid_height;
  logic [LW-1:0]  stored_length, stored_length_next;
  logic           out_valid_next;

  // Working registers.
  logic [XW-1:0]  sx, sx_next, tx, tx_next;
  logic [YW-1:0]  sy, sy_next, ty, ty_next;
  logic           q_bad, q_bad_next;
  logic [HCW-1:0] hcount, hcount_next;
  logic [HCW-1:0] hidx, hidx_next;
  logic [HCW-1:0] cidx, cidx_next;
  logic [KW-1:0]  key, key_next;
  logic [KW-1:0]  top_key, top_key_next;
  logic [KW-1:0]  last_key, last_key_next;
  logic [KW-1:0]  child_key, child_key_next;
  logic [GW-1:0]  g_cur, g_cur_next;
  logic [2:0]     dir, dir_next;
  logic [XW-1:0]  nbx, nbx_next;
  logic [YW-1:0]  nby, nby_next;
  logic           push_nb, push_nb_next;
  logic [AW-1:0]  walk, walk_next;
  logic [LW-1:0]  wn, wn_next;
  logic [LW-1:0]  wk, wk_next;
  status_t        res_status, res_status_next;
  logic [LW-1:0]  res_len, res_len_next;
  status_t        status_next;
  logic [12:0]    path_length_next;
  logic [5:0]     step_x_next, step_y_next;

  // Memory ports.
  logic           map_we, map_wdata, map_re, map_rdata;
  logic [AW-1:0]  map_waddr, map_raddr;
  logic           cost_we, cost_re;
  logic [AW-1:0]  cost_waddr, cost_raddr;
  logic [GW:0]    cost_wdata, cost_rdata;
  logic           came_we, came_re;
  logic [AW-1:0]  came_waddr, came_raddr, came_wdata, came_rdata;
  logic           heap_we, heap_re;
  logic [HAW-1:0] heap_waddr, heap_raddr;
  logic [KW-1:0]  heap_wdata, heap_rdata;
  logic           ps_we, ps_re;
  logic [PAW-1:0] ps_waddr, ps_raddr;
  logic [AW-1:0]  ps_wdata, ps_rdata;

  // Helpers.
  logic [15:0]    w_eff, h_eff;
  logic [XW-1:0]  cur_x;
  logic [YW-1:0]  cur_y;
  logic [FW-1:0]  cur_f;
  logic [HCW:0]   c_first, c_second;
  logic [HCW-1:0] p_idx;
  logic [GW-1:0]  g_step;
  logic           accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Grid size in use, clamped to the supported range.
  always_comb begin
    if (grid_width == 7'd0) begin
      w_eff = 16'd1;
    end else if (16'(grid_width) > 16'(MAX_WIDTH)) begin
      w_eff = 16'(MAX_WIDTH);
    end else begin
      w_eff = 16'(grid_width);
    end
    if (grid_height == 7'd0) begin
      h_eff = 16'd1;
    end else if (16'(grid_height) > 16'(MAX_HEIGHT)) begin
      h_eff = 16'(MAX_HEIGHT);
    end else begin
      h_eff = 16'(grid_height);
    end
  end

  assign cur_x    = top_key[XW-1:0];
  assign cur_y    = top_key[AW-1:XW];
  assign cur_f    = top_key[KW-1:AW];
  assign c_first  = {hidx, 1'b1};
  assign c_second = {1'b0, cidx} + 1'b1;
  assign p_idx    = (hidx - 1'b1) >> 1;
  assign g_step   = g_cur + 1'b1;

  // Sequencer.
  always_comb begin
    state_next         = state;
    clr_next           = clr;
    stored_length_next = stored_length;
    out_valid_next     = out_valid && out_stall;
    sx_next = sx; sy_next = sy; tx_next = tx; ty_next = ty;
    q_bad_next         = q_bad;
    hcount_next        = hcount;
    hidx_next          = hidx;
    cidx_next          = cidx;
    key_next           = key;
    top_key_next       = top_key;
    last_key_next      = last_key;
    child_key_next     = child_key;
    g_cur_next         = g_cur;
    dir_next           = dir;
    nbx_next           = nbx;
    nby_next           = nby;
    push_nb_next       = push_nb;
    walk_next          = walk;
    wn_next            = wn;
    wk_next            = wk;
    res_status_next    = res_status;
    res_len_next       = res_len;
    status_next        = status;
    path_length_next   = path_length;
    step_x_next        = step_x;
    step_y_next        = step_y;

    map_we = 1'b0; map_waddr = '0; map_wdata = 1'b0; map_re = 1'b0; map_raddr = '0;
    cost_we = 1'b0; cost_waddr = '0; cost_wdata = '0; cost_re = 1'b0; cost_raddr = '0;
    came_we = 1'b0; came_waddr = '0; came_wdata = '0; came_re = 1'b0; came_raddr = '0;
    heap_we = 1'b0; heap_waddr = '0; heap_wdata = '0; heap_re = 1'b0; heap_raddr = '0;
    ps_we = 1'b0; ps_waddr = '0; ps_wdata = '0; ps_re = 1'b0; ps_raddr = '0;

    unique case (state)
      // Clear the map to all blocked after reset.
      S_CLRMAP: begin
        map_we    = 1'b1;
        map_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == {AW{1'b1}}) begin
          state_next = S_IDLE;
        end
      end

      // Take the next item.
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_MAP: begin
              if (16'(cell_x) < 16'(MAX_WIDTH) && 16'(cell_y) < 16'(MAX_HEIGHT)) begin
                map_we    = 1'b1;
                map_waddr = {YW'(cell_y), XW'(cell_x)};
                map_wdata = passable;
              end
              res_status_next = ST_MAP_DONE;
              res_len_next    = '0;
              state_next      = S_RESULT;
            end
            REQ_QUERY: begin
              sx_next    = XW'(start_x);
              sy_next    = YW'(start_y);
              tx_next    = XW'(target_x);
              ty_next    = YW'(target_y);
              q_bad_next = (start_x == target_x && start_y == target_y) ||
                           16'(target_x) >= w_eff || 16'(target_y) >= h_eff ||
                           16'(start_x) >= w_eff || 16'(start_y) >= h_eff;
              map_re     = 1'b1;
              map_raddr  = {YW'(target_y), XW'(target_x)};
              state_next = S_QCHK;
            end
            REQ_STEP: begin
              res_len_next = stored_length;
              if (32'(step_index) < 32'(stored_length)) begin
                ps_re           = 1'b1;
                ps_raddr        = PAW'(step_index);
                res_status_next = ST_STEP_OK;
              end else begin
                res_status_next = ST_STEP_BAD;
              end
              state_next = S_RESULT;
            end
            default: begin
              res_status_next = ST_MAP_DONE;
              res_len_next    = '0;
              state_next      = S_RESULT;
            end
          endcase
        end
      end

      // Hand the result to the output register once it is free.
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          path_length_next = 13'(res_len);
          if (res_status == ST_STEP_OK) begin
            step_x_next = 6'(ps_rdata[XW-1:0]);
            step_y_next = 6'(ps_rdata[AW-1:XW]);
          end else begin
            step_x_next = '0;
            step_y_next = '0;
          end
          state_next = S_IDLE;
        end
      end

      // Trivial queries end here; others clear the seen marks.
      S_QCHK: begin
        if (q_bad || !map_rdata) begin
          stored_length_next = '0;
          res_len_next       = '0;
          res_status_next    = ST_QUERY_DONE;
          state_next         = S_RESULT;
        end else begin
          clr_next   = '0;
          state_next = S_CLRSEEN;
        end
      end

      S_CLRSEEN: begin
        cost_we    = 1'b1;
        cost_waddr = clr;
        clr_next   = clr + 1'b1;
        if (clr == {AW{1'b1}}) begin
          state_next = S_INIT;
        end
      end

      // Seed the search with the start cell.
      S_INIT: begin
        cost_we      = 1'b1;
        cost_waddr   = {sy, sx};
        cost_wdata   = {1'b1, {GW{1'b0}}};
        came_we      = 1'b1;
        came_waddr   = {sy, sx};
        came_wdata   = {sy, sx};
        key_next     = {hdist(sx, sy, tx, ty), sy, sx};
        push_nb_next = 1'b0;
        hcount_next  = '0;
        state_next   = S_PUSH;
      end

      // Heap push: append, then sift up; a full heap ends the query with no path.
      S_PUSH: begin
        if (32'(hcount) >= HEAP_DEPTH) begin
          stored_length_next = '0;
          res_len_next       = '0;
          res_status_next    = ST_QUERY_DONE;
          state_next         = S_RESULT;
        end else begin
          hidx_next   = hcount;
          hcount_next = hcount + 1'b1;
          state_next  = S_UP_RD;
        end
      end

      S_UP_RD: begin
        if (hidx == '0) begin
          heap_we    = 1'b1;
          heap_waddr = '0;
          heap_wdata = key;
          if (push_nb) begin
            dir_next   = dir + 1'b1;
            state_next = S_NB;
          end else begin
            state_next = S_POP;
          end
        end else begin
          heap_re    = 1'b1;
          heap_raddr = HAW'(p_idx);
          cidx_next  = p_idx;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = HAW'(hidx);
        if (heap_rdata <= key) begin
          heap_wdata = key;
          if (push_nb) begin
            dir_next   = dir + 1'b1;
            state_next = S_NB;
          end else begin
            state_next = S_POP;
          end
        end else begin
          heap_wdata = heap_rdata;
          hidx_next  = cidx;
          state_next = S_UP_RD;
        end
      end

      // Heap pop: take the top, move the last entry down; an empty heap ends the query with no path.
      S_POP: begin
        if (hcount == '0) begin
          stored_length_next = '0;
          res_len_next       = '0;
          res_status_next    = ST_QUERY_DONE;
          state_next         = S_RESULT;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = '0;
          state_next = S_POP_TOP;
        end
      end

      S_POP_TOP: begin
        top_key_next = heap_rdata;
        heap_re      = 1'b1;
        heap_raddr   = HAW'(hcount - 1'b1);
        hcount_next  = hcount - 1'b1;
        state_next   = S_POP_LAST;
      end

      S_POP_LAST: begin
        last_key_next = heap_rdata;
        hidx_next     = '0;
        state_next    = S_DN_RD;
      end

      S_DN_RD: begin
        if (c_first >= {1'b0, hcount}) begin
          if (hcount != '0) begin
            heap_we    = 1'b1;
            heap_waddr = HAW'(hidx);
            heap_wdata = last_key;
          end
          state_next = S_EXP;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = HAW'(c_first);
          cidx_next  = HCW'(c_first);
          state_next = S_DN_C1;
        end
      end

      S_DN_C1: begin
        child_key_next = heap_rdata;
        if (c_second < {1'b0, hcount}) begin
          heap_re    = 1'b1;
          heap_raddr = HAW'(c_second);
          state_next = S_DN_C2;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_C2: begin
        if (heap_rdata < child_key) begin
          child_key_next = heap_rdata;
          cidx_next      = HCW'(c_second);
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = HAW'(hidx);
        if (child_key >= last_key) begin
          heap_wdata = last_key;
          state_next = S_EXP;
        end else begin
          heap_wdata = child_key;
          hidx_next  = cidx;
          state_next = S_DN_RD;
        end
      end

      // Expand the popped cell unless it is the target or stale.
      S_EXP: begin
        if (cur_x == tx && cur_y == ty) begin
          walk_next  = {ty, tx};
          wn_next    = '0;
          state_next = S_W1;
        end else begin
          cost_re    = 1'b1;
          cost_raddr = {cur_y, cur_x};
          state_next = S_EXP_G;
        end
      end

      S_EXP_G: begin
        g_cur_next = cost_rdata[GW-1:0];
        if (cur_f > FW'(cost_rdata[GW-1:0]) + hdist(cur_x, cur_y, tx, ty)) begin
          state_next = S_POP;
        end else begin
          dir_next   = DIR_E;
          state_next = S_NB;
        end
      end

      // Visit the four neighbours in turn.
      S_NB: begin
        if (dir == DIR_DONE) begin
          state_next = S_POP;
        end else begin
          nbx_next = cur_x;
          nby_next = cur_y;
          case (dir)
            DIR_E: begin
              nbx_next = cur_x + 1'b1;
              map_re   = 16'(cur_x) + 16'd1 < w_eff;
            end
            DIR_W: begin
              nbx_next = cur_x - 1'b1;
              map_re   = cur_x != '0;
            end
            DIR_S: begin
              nby_next = cur_y + 1'b1;
              map_re   = 16'(cur_y) + 16'd1 < h_eff;
            end
            DIR_N: begin
              nby_next = cur_y - 1'b1;
              map_re   = cur_y != '0;
            end
            default: begin
              map_re = 1'b0;
            end
          endcase
          map_raddr  = {nby_next, nbx_next};
          cost_re    = map_re;
          cost_raddr = {nby_next, nbx_next};
          if (map_re) begin
            state_next = S_NB_CHK;
          end else begin
            dir_next = dir + 1'b1;
          end
        end
      end

      S_NB_CHK: begin
        if (map_rdata && (!cost_rdata[GW] || g_step < cost_rdata[GW-1:0])) begin
          cost_we      = 1'b1;
          cost_waddr   = {nby, nbx};
          cost_wdata   = {1'b1, g_step};
          came_we      = 1'b1;
          came_waddr   = {nby, nbx};
          came_wdata   = {cur_y, cur_x};
          key_next     = {FW'(g_step) + hdist(nbx, nby, tx, ty), nby, nbx};
          push_nb_next = 1'b1;
          state_next   = S_PUSH;
        end else begin
          dir_next   = dir + 1'b1;
          state_next = S_NB;
        end
      end

      // First walk back from the target counts the steps.
      S_W1: begin
        if (walk == {sy, sx} || 32'(wn) == NUM_CELLS) begin
          walk_next  = {ty, tx};
          wk_next    = wn;
          state_next = S_W2;
        end else begin
          came_re    = 1'b1;
          came_raddr = walk;
          state_next = S_W1D;
        end
      end

      S_W1D: begin
        walk_next  = came_rdata;
        wn_next    = wn + 1'b1;
        state_next = S_W1;
      end

      // Second walk stores the steps from the far end backwards.
      S_W2: begin
        if (walk == {sy, sx} || wk == '0) begin
          stored_length_next = wn;
          res_len_next       = wn;
          res_status_next    = ST_QUERY_DONE;
          state_next         = S_RESULT;
        end else begin
          ps_we      = 1'b1;
          ps_waddr   = PAW'(wk - 1'b1);
          ps_wdata   = walk;
          wk_next    = wk - 1'b1;
          came_re    = 1'b1;
          came_raddr = walk;
          state_next = S_W2D;
        end
      end

      S_W2D: begin
        walk_next  = came_rdata;
        state_next = S_W2;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLRMAP;
      clr           <= '0;
      out_valid     <= 1'b0;
      stored_length <= '0;
      grid_width    <= 7'd64;
      grid_height   <= 7'd64;
    end else begin
      state         <= state_next;
      clr           <= clr_next;
      out_valid     <= out_valid_next;
      stored_length <= stored_length_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    sx <= sx_next; sy <= sy_next; tx <= tx_next; ty <= ty_next;
    q_bad       <= q_bad_next;
    hcount      <= hcount_next;
    hidx        <= hidx_next;
    cidx        <= cidx_next;
    key         <= key_next;
    top_key     <= top_key_next;
    last_key    <= last_key_next;
    child_key   <= child_key_next;
    g_cur       <= g_cur_next;
    dir         <= dir_next;
    nbx         <= nbx_next;
    nby         <= nby_next;
    push_nb     <= push_nb_next;
    walk        <= walk_next;
    wn          <= wn_next;
    wk          <= wk_next;
    res_status  <= res_status_next;
    res_len     <= res_len_next;
    status      <= status_next;
    path_length <= path_length_next;
    step_x      <= step_x_next;
    step_y      <= step_y_next;
  end

  // Passable bit per cell.
  gapf_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  // Seen mark and cost so far per cell.
  gapf_ram #(.WIDTH(GW + 1), .DEPTH(MAP_DEPTH)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .re(cost_re), .raddr(cost_raddr), .rdata(cost_rdata)
  );

  // Parent cell per cell.
  gapf_ram #(.WIDTH(AW), .DEPTH(MAP_DEPTH)) u_came (
    .clk(clk), .we(came_we), .waddr(came_waddr), .wdata(came_wdata),
    .re(came_re), .raddr(came_raddr), .rdata(came_rdata)
  );

  // Open queue as a binary min-heap of (f, y, x) keys.
  gapf_ram #(.WIDTH(KW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .re(heap_re), .raddr(heap_raddr), .rdata(heap_rdata)
  );

  // Stored path steps.
  gapf_ram #(.WIDTH(AW), .DEPTH(NUM_CELLS)) u_path (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
  );

endmodule

`default_nettype wire

[design/gapf_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module gapf_checker
  import gapf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire status_t     status,
  input wire logic [12:0] path_length,
  input wire logic [5:0]  step_x,
  input wire logic [5:0]  step_y
);

  // No result comes out of reset.
  `GAPF_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // One item at a time: the block is busy right after taking an item.
  `GAPF_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "second item taken")

  // A valid step implies a non-empty stored path.
  `GAPF_ASSERT(a_step_needs_path, (out_valid && status == ST_STEP_OK) |-> (path_length != 13'd0), "step from empty path")

  // Step coordinates are zero unless a valid step is returned.
  `GAPF_ASSERT(a_step_zero, (out_valid && status != ST_STEP_OK) |-> (step_x == 6'd0 && step_y == 6'd0), "stray step cell")

  // A held result stays put.
  `GAPF_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(path_length)), "held result changed")

endmodule

bind grid_astar_path_finder gapf_checker u_gapf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .path_length(path_length), .step_x(step_x), .step_y(step_y)
);

`default_nettype wire
